@@ hw/rtl/lvws_pkg.sv @@
// Shared types, codes and constants of the letter value window sum search core.
package lvws_pkg;

    // Default sizes
    localparam int TEXT_MAX_DEF = 1024;
    localparam int WORD_MAX_DEF = 30;

    // Field and datapath widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 10;
    localparam int VAL_W    = 5;
    localparam int TARGET_W = 10;
    localparam int SUM_W    = TARGET_W + 1;

    localparam logic [TARGET_W-1:0] TARGET_CAP = '1;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_WORD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TEXT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Character constants
    localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] LOWER_BIAS  = 8'd96;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   char_code;
    } lvws_item_t;

    typedef struct packed {
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
    } lvws_span_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic pop;
        logic load;
        logic emit;
    } lvws_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic push;
        logic over;
        logic hit;
        logic span_busy;
    } lvws_status_t;

    // Alphabet value 1..26 of a letter, 0 for anything else
    function automatic logic [VAL_W-1:0] letter_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        lc = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
        begin
            lc = c + CASE_OFFSET;
        end
        if (lc >= CHAR_LO_A && lc <= CHAR_LO_Z)
        begin
            letter_value = VAL_W'(lc - LOWER_BIAS);
        end
        else
        begin
            letter_value = '0;
        end
    endfunction

endpackage

@@ hw/rtl/lvws_ctrl.sv @@
// Controller state machine of the letter value window sum search core.
module lvws_ctrl
    import lvws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  lvws_status_t status,
    output lvws_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_LOAD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.push)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.over)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_LOAD;
                end
                else if (status.hit)
                begin
                    // hold until the output register frees up
                    if (!status.span_busy)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/lvws_dp.sv @@
// Datapath of the letter value window sum search core: counters, window memory, output register.
module lvws_dp
    import lvws_pkg::*;
#(
    parameter int TEXT_MAX = TEXT_MAX_DEF,
    parameter int WORD_MAX = WORD_MAX_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  lvws_item_t   item,
    input  lvws_cmd_t    cmd,
    output lvws_status_t status,
    output logic         span_valid,
    input  logic         span_ready,
    output lvws_span_t   span
);

    localparam int AW    = $clog2(TEXT_MAX);
    localparam int CW    = $clog2(TEXT_MAX + 1);
    localparam int WCW   = $clog2(WORD_MAX + 1);
    localparam int ENT_W = AW + VAL_W;
    localparam int EXT_W = (AW > POS_W) ? AW : POS_W;

    logic [TARGET_W-1:0] target_reg;
    logic [WCW-1:0]      word_cnt_reg;
    logic [CW-1:0]       text_pos_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       tail_reg;
    logic [CW-1:0]       count_reg;
    logic                span_valid_reg;

    logic [AW-1:0]       head_pos_reg;
    logic [VAL_W-1:0]    head_val_reg;
    logic [AW-1:0]       cur_pos_reg;
    logic [ENT_W-1:0]    rd_data_reg;
    lvws_span_t          span_reg;

    logic [ENT_W-1:0]    mem [TEXT_MAX];

    logic [VAL_W-1:0]    val;
    logic                text_room;
    logic                word_room;
    logic [AW-1:0]       head_inc;
    logic [AW-1:0]       tail_inc;
    logic [AW-1:0]       pos_now;
    logic [SUM_W-1:0]    target_add;
    logic                do_push;
    logic [EXT_W-1:0]    start_ext;
    logic [EXT_W-1:0]    end_ext;

    assign val       = letter_value(item.char_code);
    assign text_room = text_pos_reg < CW'(TEXT_MAX);
    assign word_room = word_cnt_reg < WCW'(WORD_MAX);
    assign pos_now   = text_pos_reg[AW-1:0];
    assign head_inc  = (head_reg == AW'(TEXT_MAX - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == AW'(TEXT_MAX - 1)) ? '0 : tail_reg + 1'b1;
    assign target_add = {1'b0, target_reg} + SUM_W'(val);
    assign do_push   = cmd.accept && status.push;

    assign status.push      = (item.action == ACT_TEXT) && text_room && (val != '0);
    assign status.over      = sum_reg > {1'b0, target_reg};
    assign status.hit       = (target_reg != '0) && (count_reg != '0)
                              && (sum_reg == {1'b0, target_reg});
    assign status.span_busy = span_valid_reg && !span_ready;

    assign start_ext  = EXT_W'(head_pos_reg);
    assign end_ext    = EXT_W'(cur_pos_reg);
    assign span_valid = span_valid_reg;
    assign span       = span_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            word_cnt_reg   <= '0;
            text_pos_reg   <= '0;
            sum_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                case (item.action)
                    ACT_CLEAR:
                    begin
                        target_reg   <= '0;
                        word_cnt_reg <= '0;
                        text_pos_reg <= '0;
                        sum_reg      <= '0;
                        head_reg     <= '0;
                        tail_reg     <= '0;
                        count_reg    <= '0;
                    end
                    ACT_WORD:
                    begin
                        if (word_room)
                        begin
                            word_cnt_reg <= word_cnt_reg + 1'b1;
                            target_reg   <= target_add[TARGET_W] ? TARGET_CAP
                                                                 : target_add[TARGET_W-1:0];
                        end
                    end
                    ACT_TEXT:
                    begin
                        if (text_room)
                        begin
                            text_pos_reg <= text_pos_reg + 1'b1;
                        end
                        if (status.push)
                        begin
                            tail_reg  <= tail_inc;
                            count_reg <= count_reg + 1'b1;
                            sum_reg   <= sum_reg + SUM_W'(val);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.pop)
            begin
                sum_reg   <= sum_reg - SUM_W'(head_val_reg);
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.emit)
            begin
                span_valid_reg <= 1'b1;
            end
            else if (span_ready)
            begin
                span_valid_reg <= 1'b0;
            end
        end
    end

    // window memory: write on push, registered read of the next head on pop
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= {pos_now, val};
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[head_inc];
        end
    end

    // payload: cached head entry, current letter position, result
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cur_pos_reg <= pos_now;
            if (count_reg == '0)
            begin
                head_pos_reg <= pos_now;
                head_val_reg <= val;
            end
        end
        else if (cmd.load)
        begin
            head_pos_reg <= rd_data_reg[ENT_W-1:VAL_W];
            head_val_reg <= rd_data_reg[VAL_W-1:0];
        end
        if (cmd.emit)
        begin
            span_reg.start_pos <= start_ext[POS_W-1:0];
            span_reg.end_pos   <= end_ext[POS_W-1:0];
        end
    end

endmodule

@@ hw/rtl/letter_value_window_sum_search_core.sv @@
// Top level of the letter value window sum search core.
// Load the word first with word transactions: each letter (a..z, A..Z) adds its
// alphabet value 1..26 to the target, which saturates at 1023; only the first
// WORD_MAX word characters count. Then stream text transactions: each of the first
// TEXT_MAX text characters takes the next position, and a span transaction is
// produced when a letter closes a span that starts and ends on a letter and whose
// letter values add up exactly to the target (start_pos, end_pos are the low ten
// bits of the positions). A zero target never matches. A clear transaction resets
// word and text. Timing: word, clear and non-letter text transactions are taken in
// the idle state; a text letter also passes the check state, and every leading
// letter dropped from the window adds a pop step and a load step, set by the window
// memory whose read data is registered before it replaces the cached head entry.
// Drops number at most one per letter over a text. A finished span sits in an output
// register, so the next transaction is taken while it waits; a new match holds
// only when that register is still occupied. No clearing pass runs after reset.
module letter_value_window_sum_search_core
    import lvws_pkg::*;
#(
    parameter int TEXT_MAX = TEXT_MAX_DEF,
    parameter int WORD_MAX = WORD_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  lvws_item_t item,
    output logic       span_valid,
    input  logic       span_ready,
    output lvws_span_t span
);

    lvws_cmd_t    cmd;
    lvws_status_t status;

    // Sequence accept, drop and report steps
    lvws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Hold target, window and result state
    lvws_dp #(
        .TEXT_MAX (TEXT_MAX),
        .WORD_MAX (WORD_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cmd        (cmd),
        .status     (status),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span)
    );

endmodule
